/* hw/rtl/sbus_frame_receiver_decoder_unit_defines.svh */
// Assertion macros used by the checker file of the frame decoder.
`ifndef SBUS_FRAME_RECEIVER_DECODER_UNIT_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBUS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbus frame decoder check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBUS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbus frame decoder check failed");

`endif

/* hw/rtl/sbus_fr_pkg.sv */
// ----------------------------------------------------------------------------
// sbus_fr_pkg
// Types and constants of the S.BUS frame receiver and channel decoder.
// ----------------------------------------------------------------------------
package sbus_fr_pkg;

    localparam logic       OP_BYTE      = 1'b0;
    localparam logic       OP_GAP       = 1'b1;

    localparam logic [7:0] START_BYTE   = 8'h0F;
    localparam logic [7:0] END_BYTE     = 8'h00;

    localparam int         FRAME_DEPTH  = 23;
    localparam int         ADDR_W       = 5;
    localparam logic [4:0] FLAG_POS     = 5'd23;
    localparam logic [4:0] LAST_POS     = 5'd24;

    localparam int         LOST_BIT     = 2;
    localparam int         FAILSAFE_BIT = 3;

    localparam int         CH_W         = 11;
    localparam int         ACC_W        = 18;
    localparam int         CNT_W        = 5;
    localparam logic [4:0] CNT_BYTE     = 5'd8;
    localparam logic [4:0] CNT_CHAN     = 5'd11;

    localparam logic [3:0] LAST_CH_ALL  = 4'd15;
    localparam logic [3:0] LAST_CH_HALF = 4'd7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LOST     = 2'd1,
        ST_FAILSAFE = 2'd2
    } status_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]      channel_index;
        logic [CH_W-1:0] channel_value;
        logic [1:0]      signal_status;
        logic            last_channel;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic    start;
        status_t status;
    } dec_cmd_t;

endpackage

/* hw/rtl/sbus_fr_rx.sv */
// ----------------------------------------------------------------------------
// sbus_fr_rx
// Frame framing: hunts for the start byte, stores frame bytes, checks the end
// byte and launches the channel decoder.
// ----------------------------------------------------------------------------
module sbus_fr_rx (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat,
    input  sbus_fr_pkg::in_item_t item,
    output sbus_fr_pkg::mem_wr_t  wr,
    output sbus_fr_pkg::dec_cmd_t cmd
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_RECV    = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [4:0] idx_reg, idx_next;
    logic [4:0] idx_inc;
    logic [7:0] flags_reg, flags_next;

    assign idx_inc = 5'(idx_reg + 5'd1);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        flags_next = flags_reg;
        wr         = '0;
        cmd.start  = 1'b0;
        if (flags_reg[sbus_fr_pkg::FAILSAFE_BIT])
        begin
            cmd.status = sbus_fr_pkg::ST_FAILSAFE;
        end
        else if (flags_reg[sbus_fr_pkg::LOST_BIT])
        begin
            cmd.status = sbus_fr_pkg::ST_LOST;
        end
        else
        begin
            cmd.status = sbus_fr_pkg::ST_OK;
        end

        if (beat)
        begin
            if (item.opcode == sbus_fr_pkg::OP_GAP)
            begin
                phase_next = PH_HUNT;
            end
            else
            begin
                case (phase_reg)
                    PH_RECV:
                    begin
                        idx_next = idx_inc;
                        if (idx_inc >= 5'd1 && idx_inc <= sbus_fr_pkg::FLAG_POS)
                        begin
                            wr.en   = 1'b1;
                            wr.addr = 5'(idx_inc - 5'd1);
                            wr.data = item.rx_byte;
                        end
                        if (idx_inc == sbus_fr_pkg::FLAG_POS)
                        begin
                            flags_next = item.rx_byte;
                        end
                        if (idx_inc >= sbus_fr_pkg::LAST_POS)
                        begin
                            phase_next = PH_HUNT;
                            if (idx_inc == sbus_fr_pkg::LAST_POS &&
                                item.rx_byte == sbus_fr_pkg::END_BYTE)
                            begin
                                cmd.start = 1'b1;
                            end
                        end
                    end
                    PH_DISCARD:
                    begin
                        phase_next = PH_DISCARD;
                    end
                    default:
                    begin
                        if (item.rx_byte == sbus_fr_pkg::START_BYTE)
                        begin
                            idx_next   = 5'd0;
                            phase_next = PH_RECV;
                        end
                        else
                        begin
                            phase_next = PH_DISCARD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= 5'd0;
            flags_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            flags_reg <= flags_next;
        end
    end

endmodule

/* hw/rtl/sbus_fr_dec.sv */
// ----------------------------------------------------------------------------
// sbus_fr_dec
// Frame store and channel unpacker: one byte-merge shifter and an 11-bit
// extractor, sequenced channel by channel, feeding an output register.
// ----------------------------------------------------------------------------
module sbus_fr_dec (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbus_fr_pkg::mem_wr_t   wr,
    input  sbus_fr_pkg::dec_cmd_t  cmd,
    input  logic                   all_ch,
    input  logic                   out_stall,
    output logic                   busy,
    output logic                   out_valid,
    output sbus_fr_pkg::out_item_t out_data
);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_FETCH = 4'b0010,
        D_LOAD  = 4'b0100,
        D_EMIT  = 4'b1000
    } dstate_t;

    logic [7:0] frame_mem [sbus_fr_pkg::FRAME_DEPTH];
    logic [7:0] rd_data_reg;

    dstate_t                          state_reg, state_next;
    logic [sbus_fr_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [sbus_fr_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sbus_fr_pkg::CNT_W-1:0]    cnt_add;
    logic [3:0]                       ch_reg, ch_next;
    logic [sbus_fr_pkg::ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    sbus_fr_pkg::status_t             status_reg, status_next;
    logic                             out_valid_reg, out_valid_next;
    sbus_fr_pkg::out_item_t           out_data_reg, out_data_next;
    logic                             last_ch;
    logic                             out_free;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            frame_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= frame_mem[rd_ptr_reg];
    end

    assign last_ch  = (ch_reg == (all_ch ? sbus_fr_pkg::LAST_CH_ALL
                                         : sbus_fr_pkg::LAST_CH_HALF));
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_add  = cnt_reg + sbus_fr_pkg::CNT_BYTE;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        rd_ptr_next    = rd_ptr_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            D_FETCH:
            begin
                // read issued this cycle, data lands in rd_data_reg
                rd_ptr_next = sbus_fr_pkg::ADDR_W'(rd_ptr_reg + 1'b1);
                state_next  = D_LOAD;
            end
            D_LOAD:
            begin
                acc_next   = acc_reg | (sbus_fr_pkg::ACC_W'(rd_data_reg) << cnt_reg);
                cnt_next   = cnt_add;
                state_next = (cnt_add >= sbus_fr_pkg::CNT_CHAN) ? D_EMIT : D_FETCH;
            end
            D_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.channel_index = ch_reg;
                    out_data_next.channel_value = acc_reg[sbus_fr_pkg::CH_W-1:0];
                    out_data_next.signal_status = status_reg;
                    out_data_next.last_channel  = last_ch;
                    acc_next   = acc_reg >> sbus_fr_pkg::CH_W;
                    cnt_next   = cnt_reg - sbus_fr_pkg::CNT_CHAN;
                    ch_next    = 4'(ch_reg + 4'd1);
                    // fewer than eleven bits remain, so refill next unless this was the last channel
                    state_next = last_ch ? D_IDLE : D_FETCH;
                end
            end
            default:
            begin
                if (cmd.start)
                begin
                    acc_next    = '0;
                    cnt_next    = '0;
                    ch_next     = 4'd0;
                    rd_ptr_next = '0;
                    status_next = cmd.status;
                    state_next  = D_FETCH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= D_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            ch_reg        <= 4'd0;
            rd_ptr_reg    <= '0;
            status_reg    <= sbus_fr_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            rd_ptr_reg    <= rd_ptr_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign busy      = (state_reg != D_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/sbus_frame_receiver_decoder_unit.sv */
// ----------------------------------------------------------------------------
// sbus_frame_receiver_decoder_unit
// S.BUS frame receiver and 11-bit channel decoder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one beat per received byte or per
// gap event (receive buffer empty). A byte that causes no result is taken
// without a stall while the decoder is idle. The closing 0x00 byte of a good
// 25-byte frame starts the decoder, and in_stall stays high until its last
// channel beat has been loaded into the output register.
// Output channel (out_valid/out_stall/out_data): one beat per channel, 8 or 16
// of them, last_channel set on the final one. For each channel the decoder
// reads bytes from the frame store (FETCH) and merges them into a bit
// accumulator (LOAD) until eleven bits are held, then loads the channel into
// the output register (EMIT).
// A stalled output beat holds; the decoder waits in EMIT until it is taken.
// cfg_we/cfg_wdata write decode_all_channels (1: sixteen channels, 0: eight);
// write it only while no frame is being decoded.
// Reset: hunting for a start byte, sixteen-channel mode, output empty. The
// frame store needs no clearing; every frame rewrites it before it is read.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_decoder_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sbus_fr_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sbus_fr_pkg::out_item_t out_data,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata
);

    logic                  all_ch_reg;
    logic                  busy;
    logic                  in_beat;
    sbus_fr_pkg::mem_wr_t  wr;
    sbus_fr_pkg::dec_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_ch_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            all_ch_reg <= cfg_wdata;
        end
    end

    assign in_stall = busy;
    assign in_beat  = in_valid && !busy;

    sbus_fr_rx u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (in_beat),
        .item  (in_data),
        .wr    (wr),
        .cmd   (cmd)
    );

    sbus_fr_dec u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .cmd       (cmd),
        .all_ch    (all_ch_reg),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

/* hw/rtl/sbus_fr_chk.sv */
// ----------------------------------------------------------------------------
// sbus_fr_chk
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "sbus_frame_receiver_decoder_unit_defines.svh"

module sbus_fr_chk (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input sbus_fr_pkg::out_item_t out_data
);

    // stalled output beat holds
    `SBUS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // a frame ends on channel 7 or channel 15
    `SBUS_ASSERT_IMP(a_last_idx, out_valid && out_data.last_channel,
        out_data.channel_index == 4'd7 || out_data.channel_index == 4'd15)

    // more channels pending: input stays closed
    `SBUS_ASSERT_IMP(a_mid_frame_busy, out_valid && !out_stall && !out_data.last_channel,
        in_stall)

    // with the input open only a final channel beat can be waiting
    `SBUS_ASSERT_IMP(a_idle_last, !in_stall && out_valid, out_data.last_channel)

endmodule

bind sbus_frame_receiver_decoder_unit sbus_fr_chk u_sbus_fr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
